@@ design/jsu_pkg.sv @@
// Package for the Jacobi symbol unit: field widths, symbol codes, sign-flip residues and the
// sequencer state type. No dependencies.
package jsu_pkg;

  localparam int VALUE_W  = 64;
  localparam int SYMBOL_W = 2;

  // Symbol codes, two's complement.
  localparam logic signed [SYMBOL_W-1:0] SYM_ZERO = 2'sb00;
  localparam logic signed [SYMBOL_W-1:0] SYM_POS  = 2'sb01;
  localparam logic signed [SYMBOL_W-1:0] SYM_NEG  = 2'sb11;

  // Residues of the bottom number mod 8 that flip the sign when a two is removed.
  localparam logic [2:0] MOD8_FLIP_LO = 3'd3;
  localparam logic [2:0] MOD8_FLIP_HI = 3'd5;
  // Residue mod 4 that, on both numbers, flips the sign at a swap.
  localparam logic [1:0] MOD4_FLIP = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } jsu_state_t;

endpackage

@@ design/jsu_if.sv @@
// Channel interfaces of the Jacobi symbol unit: operand pair in, symbol and invalid-modulus flag out.
// Depends on jsu_pkg.
interface jsu_operand_if;
  import jsu_pkg::*;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic [VALUE_W-1:0] modulus;
  modport source (output valid, output value, output modulus, input ready);
  modport sink   (input valid, input value, input modulus, output ready);
endinterface

interface jsu_result_if;
  import jsu_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SYMBOL_W-1:0] symbol;
  logic                       invalid_modulus;
  modport source (output valid, output symbol, output invalid_modulus, input ready);
  modport sink   (input valid, input symbol, input invalid_modulus, output ready);
endinterface

@@ design/jacobi_symbol_unit_top.sv @@
// Operation: one shift or one compare-and-subtract per cycle in the shared step
// unit until the first number reaches zero; an even or zero modulus is flagged
// without any steps. Throughput: one item at a time; the next operand transfer
// is taken the cycle after the result transfer. Reset (rst, synchronous) returns
// to idle and drops any pending result.
module jacobi_symbol_unit_top #(
  parameter int WIDTH = 64
) (
  input logic          clk,
  input logic          rst,
  jsu_operand_if.sink  operands,
  jsu_result_if.source result
);
  import jsu_pkg::*;

  jsu_state_t                 state, state_next;
  logic [WIDTH-1:0]           a, a_next;
  logic [WIDTH-1:0]           m, m_next;
  logic                       neg, neg_next;
  logic signed [SYMBOL_W-1:0] sym_q, sym_next;
  logic                       inv_q, inv_next;

  logic             accept;
  logic [WIDTH-1:0] m_in;
  logic             a_lt_m;
  logic [WIDTH-1:0] big, low;

  assign accept = operands.valid && operands.ready;
  assign m_in   = operands.modulus[WIDTH-1:0];

  // Shared step unit: subtract the smaller odd number from the larger one.
  assign a_lt_m = a < m;
  assign big    = a_lt_m ? m : a;
  assign low    = a_lt_m ? a : m;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
    a     <= a_next;
    m     <= m_next;
    neg   <= neg_next;
    sym_q <= sym_next;
    inv_q <= inv_next;
  end

  always_comb begin
    state_next = state;
    a_next     = a;
    m_next     = m;
    neg_next   = neg;
    sym_next   = sym_q;
    inv_next   = inv_q;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          a_next   = operands.value[WIDTH-1:0];
          m_next   = m_in;
          neg_next = 1'b0;
          sym_next = SYM_ZERO;
          // A zero modulus is even as well.
          if (!m_in[0]) begin
            inv_next   = 1'b1;
            state_next = ST_DONE;
          end else begin
            inv_next   = 1'b0;
            state_next = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (a == '0) begin
          // The bottom number is now the gcd; a common factor gives zero.
          if (m == WIDTH'(1)) begin
            sym_next = neg ? SYM_NEG : SYM_POS;
          end else begin
            sym_next = SYM_ZERO;
          end
          state_next = ST_DONE;
        end else if (!a[0]) begin
          a_next = a >> 1;
          if (m[2:0] == MOD8_FLIP_LO || m[2:0] == MOD8_FLIP_HI) begin
            neg_next = !neg;
          end
        end else begin
          // Both odd: swap if needed (reciprocity), then subtract.
          a_next = big - low;
          m_next = low;
          if (a_lt_m && a[1:0] == MOD4_FLIP && m[1:0] == MOD4_FLIP) begin
            neg_next = !neg;
          end
        end
      end
      ST_DONE: begin
        if (result.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign operands.ready         = (state == ST_IDLE);
  assign result.valid           = (state == ST_DONE);
  assign result.symbol          = sym_q;
  assign result.invalid_modulus = inv_q;

endmodule

@@ design/jsu_checker.sv @@
// Port-level checks for the Jacobi symbol unit, attached to the top level by
// the bind statement at the end of the file. Depends on jsu_pkg.
module jsu_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic [jsu_pkg::VALUE_W-1:0]          modulus,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [jsu_pkg::SYMBOL_W-1:0]  symbol,
  input logic                                 invalid_modulus
);
  import jsu_pkg::*;

  // An invalid modulus always reports a zero symbol.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && invalid_modulus |-> symbol == SYM_ZERO)
    else $error("invalid modulus with nonzero symbol");

  // The unit works on one item at a time.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("operands taken while busy");

  // A pending result blocks new operands.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("ready for operands while a result waits");

  // An even modulus is flagged on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !modulus[0] |=> out_valid && invalid_modulus)
    else $error("even modulus not flagged");

  // A stalled result holds.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(symbol) && $stable(invalid_modulus))
    else $error("stalled result changed");

endmodule

bind jacobi_symbol_unit_top jsu_checker u_jsu_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (operands.valid),
  .in_ready        (operands.ready),
  .modulus         (operands.modulus),
  .out_valid       (result.valid),
  .out_ready       (result.ready),
  .symbol          (result.symbol),
  .invalid_modulus (result.invalid_modulus)
);
